@@ src/srecord_loader_parser_top_defines.svh @@
// Assertion macros used by the checker file srec_checker.sv.
`ifndef SRECORD_LOADER_PARSER_TOP_DEFINES_SVH
`define SRECORD_LOADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SREC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srec check failed: same-cycle rule");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SREC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srec check failed: next-cycle rule");

`endif

@@ src/srec_pkg.sv @@
package srec_pkg;

  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindStart = 2'd1,
    KindNoS   = 2'd2,
    KindShort = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       result_kind;
    logic [15:0] target_address;
    logic [7:0]  data_byte;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t item;
  } queue_wr_t;

  typedef struct packed {
    logic    valid;
    result_t item;
  } queue_rd_t;

  localparam logic [7:0] CharS          = 8'h53;
  localparam logic [7:0] CharNewline    = 8'd10;
  localparam logic [7:0] HexAlphaOffset = 8'd55;
  localparam logic [3:0] TypeData       = 4'd1;
  localparam logic [3:0] TypeStart      = 4'd9;
  localparam logic [7:0] CountOverhead  = 8'd3;
  localparam int         HeaderChars    = 8;
  localparam int         MaxLineCharsDefault = 128;
  localparam int         QueueDepth     = 2;

  // {digit ok, value}; only 0-9 and uppercase A-F count as digits
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] t;
    t = c - HexAlphaOffset;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_decode = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_decode = {1'b1, t[3:0]};
    end else begin
      hex_decode = 5'd0;
    end
  endfunction

endpackage

@@ src/srec_if.sv @@
interface srec_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source(output valid, output char_code, input ready);
  modport sink(input valid, input char_code, output ready);
endinterface

interface srec_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] target_address;
  logic [7:0]  data_byte;

  modport source(output valid, output result_kind, output target_address,
                 output data_byte, input ready);
  modport sink(input valid, input result_kind, input target_address,
               input data_byte, output ready);
endinterface

@@ src/srec_front.sv @@
module srec_front #(
  parameter int MaxLineChars = srec_pkg::MaxLineCharsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          char_code_i,
  input  logic                queue_full_i,
  output logic                ready_o,
  output srec_pkg::queue_wr_t wr_o
);

  // data pairs that still end within the line limit
  localparam int MaxDataBytes = (MaxLineChars - srec_pkg::HeaderChars) / 2;

  localparam logic [3:0] PosFirst = 4'd0;
  localparam logic [3:0] PosType  = 4'd1;
  localparam logic [3:0] PosCntHi = 4'd2;
  localparam logic [3:0] PosCntLo = 4'd3;
  localparam logic [3:0] PosAddr0 = 4'd4;
  localparam logic [3:0] PosAddr1 = 4'd5;
  localparam logic [3:0] PosAddr2 = 4'd6;
  localparam logic [3:0] PosAddr3 = 4'd7;
  localparam logic [3:0] PosDataH = 4'd8;
  localparam logic [3:0] PosDataL = 4'd9;

  logic [3:0]  pos_q, pos_d;
  logic [3:0]  type_q, type_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] addr_q, addr_d;
  logic [3:0]  nib_q, nib_d;
  logic [7:0]  done_q, done_d;
  logic        bad_q, bad_d;

  logic        accept;
  logic [4:0]  hex;
  logic [7:0]  byte_val;
  logic        write_ok;

  assign ready_o  = !queue_full_i;
  assign accept   = valid_i && ready_o;
  assign hex      = srec_pkg::hex_decode(char_code_i);
  assign byte_val = {nib_q, hex[3:0]};
  assign write_ok = !bad_q && (type_q == srec_pkg::TypeData)
                 && (count_q >= srec_pkg::CountOverhead)
                 && (done_q < (count_q - srec_pkg::CountOverhead))
                 && (32'(done_q) < MaxDataBytes);

  always_comb begin
    pos_d   = pos_q;
    type_d  = type_q;
    count_d = count_q;
    addr_d  = addr_q;
    nib_d   = nib_q;
    done_d  = done_q;
    bad_d   = bad_q;
    wr_o    = '0;
    if (accept) begin
      if (char_code_i == srec_pkg::CharNewline) begin
        if (32'(pos_q) < srec_pkg::HeaderChars) begin
          wr_o.push             = 1'b1;
          wr_o.item.result_kind = srec_pkg::KindShort;
        end else if (!bad_q && type_q == srec_pkg::TypeStart) begin
          wr_o.push                = 1'b1;
          wr_o.item.result_kind    = srec_pkg::KindStart;
          wr_o.item.target_address = addr_q;
        end
        pos_d   = PosFirst;
        type_d  = '0;
        count_d = '0;
        addr_d  = '0;
        nib_d   = '0;
        done_d  = '0;
        bad_d   = 1'b0;
      end else if (pos_q == PosFirst) begin
        pos_d = PosType;
        if (char_code_i != srec_pkg::CharS) begin
          bad_d                 = 1'b1;
          wr_o.push             = 1'b1;
          wr_o.item.result_kind = srec_pkg::KindNoS;
        end
      end else if (hex[4]) begin
        unique case (pos_q)
          PosType: begin
            type_d = hex[3:0];
            pos_d  = PosCntHi;
          end
          PosCntHi: begin
            nib_d = hex[3:0];
            pos_d = PosCntLo;
          end
          PosCntLo: begin
            count_d = byte_val;
            pos_d   = PosAddr0;
          end
          PosAddr0, PosAddr1, PosAddr2, PosAddr3: begin
            addr_d = {addr_q[11:0], hex[3:0]};
            pos_d  = pos_q + 4'd1;
          end
          PosDataH: begin
            nib_d = hex[3:0];
            pos_d = PosDataL;
          end
          default: begin
            pos_d = PosDataH;
            if (write_ok) begin
              wr_o.push                = 1'b1;
              wr_o.item.result_kind    = srec_pkg::KindWrite;
              wr_o.item.target_address = addr_q + {8'd0, done_q};
              wr_o.item.data_byte      = byte_val;
              done_d                   = done_q + 8'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosFirst;
      type_q  <= '0;
      count_q <= '0;
      addr_q  <= '0;
      nib_q   <= '0;
      done_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      type_q  <= type_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      nib_q   <= nib_d;
      done_q  <= done_d;
      bad_q   <= bad_d;
    end
  end

endmodule

@@ src/srec_fifo.sv @@
module srec_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srec_pkg::queue_wr_t wr_i,
  input  logic                pop_i,
  output logic                full_o,
  output srec_pkg::queue_rd_t rd_o
);

  localparam int PtrW = $clog2(srec_pkg::QueueDepth);
  localparam int CntW = $clog2(srec_pkg::QueueDepth + 1);

  srec_pkg::result_t mem_q [srec_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(srec_pkg::QueueDepth));
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.item  = mem_q[rd_ptr_q];
  assign do_push    = wr_i.push && !full_o;
  assign do_pop     = pop_i && rd_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == srec_pkg::QueueDepth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == srec_pkg::QueueDepth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

endmodule

@@ src/srec_back.sv @@
module srec_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srec_pkg::queue_rd_t rd_i,
  output logic                pop_o,
  input  logic                ready_i,
  output logic                valid_o,
  output srec_pkg::result_t   item_o
);

  logic              valid_q;
  srec_pkg::result_t item_q;

  // refill the output beat when it is empty or being taken
  assign pop_o   = rd_i.valid && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || ready_i) begin
      valid_q <= rd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= rd_i.item;
    end
  end

endmodule

@@ src/srecord_loader_parser_top.sv @@
// S-record (S1/S9) loader parser.
// char_i takes one ASCII character per beat; a newline ends the record.
// res_o gives one beat per memory byte write (kind 0), start address
// (kind 1), missing-S error (kind 2) or too-short error (kind 3).
// Throughput: one character per cycle while the queue is not full,
// whether or not the character produces a result.
// A result is pushed by the front parser into a two-entry queue when
// its character is taken, and the output register loads it from the
// queue when the register is empty or its beat is being taken.
// The front parser holds its header fields in registers set on each
// accepted beat; the queue and output register decouple it from res_o.
// A stall on res_o holds the output beat; the queue then fills and
// char_i.ready drops once both queue entries are taken.
// Reset clears the parser to the start of a line and empties the queue
// and the output register.
module srecord_loader_parser_top #(
  parameter int MaxLineChars = srec_pkg::MaxLineCharsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  srec_char_if.sink    char_i,
  srec_res_if.source   res_o
);

  srec_pkg::queue_wr_t wr;
  srec_pkg::queue_rd_t rd;
  srec_pkg::result_t   out_item;
  logic                queue_full;
  logic                pop;

  srec_front #(
    .MaxLineChars(MaxLineChars)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (char_i.valid),
    .char_code_i (char_i.char_code),
    .queue_full_i(queue_full),
    .ready_o     (char_i.ready),
    .wr_o        (wr)
  );

  srec_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (wr),
    .pop_i (pop),
    .full_o(queue_full),
    .rd_o  (rd)
  );

  srec_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd),
    .pop_o  (pop),
    .ready_i(res_o.ready),
    .valid_o(res_o.valid),
    .item_o (out_item)
  );

  assign res_o.result_kind    = out_item.result_kind;
  assign res_o.target_address = out_item.target_address;
  assign res_o.data_byte      = out_item.data_byte;

endmodule

@@ src/srec_checker.sv @@
`include "srecord_loader_parser_top_defines.svh"

module srec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_i,
  input logic [15:0] target_address_i,
  input logic [7:0]  data_byte_i
);

  logic        out_stall;
  logic        is_error;
  logic [25:0] out_payload;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign is_error    = (result_kind_i == srec_pkg::KindNoS)
                    || (result_kind_i == srec_pkg::KindShort);
  assign out_payload = {result_kind_i, target_address_i, data_byte_i};

  `SREC_ASSERT_NEXT(a_hold_valid, out_stall, out_valid_i)
  `SREC_ASSERT_NEXT(a_hold_payload, out_stall, $stable(out_payload))
  `SREC_ASSERT_NOW(a_data_only_on_write, out_valid_i && result_kind_i != srec_pkg::KindWrite, data_byte_i == 8'd0)
  `SREC_ASSERT_NOW(a_error_no_address, out_valid_i && is_error, target_address_i == 16'd0)

endmodule

bind srecord_loader_parser_top srec_checker u_srec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .result_kind_i   (res_o.result_kind),
  .target_address_i(res_o.target_address),
  .data_byte_i     (res_o.data_byte)
);
